// File: hw/rtl/sdspi_pkg.sv
// shared types, constants and helpers for the sd card spi-mode master
// no dependencies; used by sdspi_cfg, sdspi_fsm, the top level and the testbench
package sdspi_pkg;

  // block geometry
  localparam int BLOCK_BYTES = 512;
  localparam int BYTE_CNT_W  = $clog2(BLOCK_BYTES) + 1;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [7:0]  SLOW_DIV_RST  = 8'd101;
  localparam logic [7:0]  FAST_DIV_RST  = 8'd3;
  localparam logic [11:0] RETRY_LIM_RST = 12'd1000;
  localparam logic [15:0] TOKEN_LIM_RST = 16'd10000;
  localparam logic [7:0]  RESP_LIM_RST  = 8'd10;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOW_DIV  = 3'd0,
    CFG_FAST_DIV  = 3'd1,
    CFG_RETRY_LIM = 3'd2,
    CFG_TOKEN_LIM = 3'd3,
    CFG_RESP_LIM  = 3'd4
  } cfg_idx_e;

  // request codes
  localparam logic [1:0] REQ_INIT = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_BYTE = 2'd2;

  // completion status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CMD0_FAIL   = 3'd1,
    ST_CMD8_FAIL   = 3'd2,
    ST_ACMD41_FAIL = 3'd3,
    ST_READ_REJ    = 3'd4,
    ST_NO_TOKEN    = 3'd5
  } status_e;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
  localparam logic [5:0] CMD_READ_ONE  = 6'd17;
  localparam logic [5:0] CMD_SEND_OP   = 6'd41;
  localparam logic [5:0] CMD_APP       = 6'd55;
  localparam logic [5:0] CMD_READ_OCR  = 6'd58;

  // command arguments and crc bytes
  localparam logic [7:0]  CRC_CMD0     = 8'h95;
  localparam logic [7:0]  CRC_CMD8     = 8'h87;
  localparam logic [7:0]  CRC_NONE     = 8'hFF;
  localparam logic [31:0] ARG_CMD8     = 32'h0000_01AA;
  localparam logic [31:0] ARG_ACMD41   = 32'h4000_0000;
  localparam logic [31:0] ARG_BLOCKLEN = 32'(BLOCK_BYTES);

  // bus bytes and response bits
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] START_TOKEN = 8'hFE;
  localparam logic [7:0] CHECK_BYTE  = 8'hAA;
  localparam logic [7:0] R1_IDLE     = 8'h01;
  localparam logic [7:0] R1_READY    = 8'h00;
  localparam int         R1_BUSY_BIT = 7;
  localparam int         OCR_CCS_BIT = 6;

  // byte counts of the fixed sequences
  localparam int WAKE_BYTES  = 10;
  localparam int FRAME_BYTES = 6;
  localparam int TRAIL_BYTES = 4;
  localparam int CRC_BYTES   = 2;
  localparam int ADDR_SHIFT  = $clog2(BLOCK_BYTES);

  // configuration register set
  typedef struct packed {
    logic [7:0]  slow_div;
    logic [7:0]  fast_div;
    logic [11:0] retry_lim;
    logic [15:0] token_lim;
    logic [7:0]  resp_lim;
  } cfg_t;

  // one request beat
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] block_num;
    logic [7:0]  rx_byte;
  } req_t;

  // one result beat
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       chip_select;
    logic [7:0] clock_divider;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       data_last;
    logic       done_res;
    logic [2:0] status;
    logic       high_capacity;
  } res_t;

  // six-byte command frame: start bits, index, argument, crc
  function automatic logic [47:0] cmd_frame(input logic [5:0] idx, input logic [31:0] arg,
                                            input logic [7:0] crc);
    cmd_frame = {2'b01, idx, arg, crc};
  endfunction

endpackage

// File: hw/rtl/sdspi_req_if.sv
// request channel: valid/ready handshake with the request payload
// no dependencies
interface sdspi_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] block_num;
  logic [7:0]  rx_byte;

  modport source (output valid, output req_type, output block_num, output rx_byte,
                  input ready);
  modport sink   (input valid, input req_type, input block_num, input rx_byte,
                  output ready);
endinterface

// File: hw/rtl/sdspi_res_if.sv
// result channel: valid/ready handshake with the result payload
// no dependencies
interface sdspi_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       chip_select;
  logic [7:0] clock_divider;
  logic [7:0] data_byte;
  logic       data_valid;
  logic       data_last;
  logic       done_res;
  logic [2:0] status;
  logic       high_capacity;

  modport source (output valid, output tx_byte, output tx_valid, output chip_select,
                  output clock_divider, output data_byte, output data_valid,
                  output data_last, output done_res, output status, output high_capacity,
                  input ready);
  modport sink   (input valid, input tx_byte, input tx_valid, input chip_select,
                  input clock_divider, input data_byte, input data_valid,
                  input data_last, input done_res, input status, input high_capacity,
                  output ready);
endinterface

// File: hw/rtl/sdspi_cfg.sv
// configuration register file for the sd card spi-mode master
// depends on sdspi_pkg
module sdspi_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sdspi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdspi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output sdspi_pkg::cfg_t                  cfg_o
);

  sdspi_pkg::cfg_t cfg_q;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow_div  <= sdspi_pkg::SLOW_DIV_RST;
      cfg_q.fast_div  <= sdspi_pkg::FAST_DIV_RST;
      cfg_q.retry_lim <= sdspi_pkg::RETRY_LIM_RST;
      cfg_q.token_lim <= sdspi_pkg::TOKEN_LIM_RST;
      cfg_q.resp_lim  <= sdspi_pkg::RESP_LIM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sdspi_pkg::CFG_SLOW_DIV:  cfg_q.slow_div  <= cfg_data_i[7:0];
        sdspi_pkg::CFG_FAST_DIV:  cfg_q.fast_div  <= cfg_data_i[7:0];
        sdspi_pkg::CFG_RETRY_LIM: cfg_q.retry_lim <= cfg_data_i[11:0];
        sdspi_pkg::CFG_TOKEN_LIM: cfg_q.token_lim <= cfg_data_i[15:0];
        sdspi_pkg::CFG_RESP_LIM:  cfg_q.resp_lim  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/sdspi_fsm.sv
// protocol sequencer: card state, next-byte decision and the result register
// depends on sdspi_pkg
module sdspi_fsm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sdspi_pkg::cfg_t cfg_i,
  input  logic            fire_i,
  input  sdspi_pkg::req_t item_i,
  input  logic            out_ready_i,
  output logic            res_valid_o,
  output sdspi_pkg::res_t res_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAKE, PH_CMD, PH_RESP, PH_TRAIL8, PH_OCR, PH_TOKEN, PH_DATA, PH_CRC
  } phase_e;

  localparam int BW = sdspi_pkg::BYTE_CNT_W;

  phase_e                phase_q, phase_d;
  logic [BW-1:0]         byte_q, byte_d, byte_inc;
  logic [15:0]           poll_q, poll_d, poll_inc;
  logic [11:0]           retry_q, retry_d, retry_inc;
  logic [47:0]           frame_q, frame_d;
  logic                  hc_q, hc_d;
  logic [7:0]            lr_q, lr_d, lr_eff;
  logic [7:0]            div_q, div_d;
  logic                  sel_q, sel_d;
  logic                  res_valid_q, res_valid_d;
  sdspi_pkg::res_t       res_q, res_d;

  logic                  has_res;
  logic                  launch;
  logic [47:0]           launch_frame;
  logic                  fin_en;
  sdspi_pkg::status_e    fin_st;
  logic [7:0]            resp_lim_eff;
  logic [15:0]           token_lim_eff;
  logic [11:0]           retry_lim_eff;
  logic [31:0]           rd_addr;
  logic [5:0]            cur_cmd;
  logic [7:0]            rx;

  // limits of zero behave as one
  assign resp_lim_eff  = (cfg_i.resp_lim  == '0) ? 8'd1  : cfg_i.resp_lim;
  assign token_lim_eff = (cfg_i.token_lim == '0) ? 16'd1 : cfg_i.token_lim;
  assign retry_lim_eff = (cfg_i.retry_lim == '0) ? 12'd1 : cfg_i.retry_lim;

  assign byte_inc  = byte_q + 1'b1;
  assign poll_inc  = poll_q + 1'b1;
  assign retry_inc = retry_q + 1'b1;
  assign cur_cmd   = frame_q[45:40];
  assign rx        = item_i.rx_byte;
  assign lr_eff    = (byte_q == '0) ? rx : lr_q;
  assign rd_addr   = hc_q ? item_i.block_num
                          : {item_i.block_num[31-sdspi_pkg::ADDR_SHIFT:0],
                             {sdspi_pkg::ADDR_SHIFT{1'b0}}};

  // next state and result for one beat
  always_comb begin
    phase_d      = phase_q;
    byte_d       = byte_q;
    poll_d       = poll_q;
    retry_d      = retry_q;
    frame_d      = frame_q;
    hc_d         = hc_q;
    lr_d         = lr_q;
    div_d        = div_q;
    sel_d        = sel_q;
    has_res      = 1'b0;
    launch       = 1'b0;
    launch_frame = '0;
    fin_en       = 1'b0;
    fin_st       = sdspi_pkg::ST_OK;
    res_d        = '0;
    res_d.tx_byte = sdspi_pkg::IDLE_BYTE;

    if (fire_i) begin
      case (item_i.req_type)
        sdspi_pkg::REQ_INIT: begin
          has_res         = 1'b1;
          hc_d            = 1'b0;
          div_d           = cfg_i.slow_div;
          sel_d           = 1'b0;
          phase_d         = PH_WAKE;
          byte_d          = '0;
          res_d.tx_valid  = 1'b1;
        end
        sdspi_pkg::REQ_READ: begin
          has_res      = 1'b1;
          launch       = 1'b1;
          launch_frame = sdspi_pkg::cmd_frame(sdspi_pkg::CMD_READ_ONE, rd_addr,
                                              sdspi_pkg::CRC_NONE);
        end
        sdspi_pkg::REQ_BYTE: begin
          has_res = (phase_q != PH_IDLE);
          res_d.tx_valid = 1'b1;
          case (phase_q)
            // idle clocks with chip select off
            PH_WAKE: begin
              byte_d = byte_inc;
              if (byte_inc >= BW'(sdspi_pkg::WAKE_BYTES)) begin
                sel_d        = 1'b1;
                launch       = 1'b1;
                launch_frame = sdspi_pkg::cmd_frame(sdspi_pkg::CMD_GO_IDLE, 32'd0,
                                                    sdspi_pkg::CRC_CMD0);
              end
            end
            // shift out the remaining frame bytes
            PH_CMD: begin
              if (byte_q < BW'(sdspi_pkg::FRAME_BYTES)) begin
                byte_d = byte_inc;
                case (byte_q[2:0])
                  3'd1:    res_d.tx_byte = frame_q[39:32];
                  3'd2:    res_d.tx_byte = frame_q[31:24];
                  3'd3:    res_d.tx_byte = frame_q[23:16];
                  3'd4:    res_d.tx_byte = frame_q[15:8];
                  default: res_d.tx_byte = frame_q[7:0];
                endcase
              end else begin
                phase_d = PH_RESP;
                poll_d  = '0;
              end
            end
            // poll for an r1 response and act on it
            PH_RESP: begin
              poll_d = poll_inc;
              if (!rx[sdspi_pkg::R1_BUSY_BIT] || poll_inc >= {8'd0, resp_lim_eff}) begin
                lr_d = rx;
                case (cur_cmd)
                  sdspi_pkg::CMD_GO_IDLE: begin
                    if (rx != sdspi_pkg::R1_IDLE) begin
                      fin_en = 1'b1;
                      fin_st = sdspi_pkg::ST_CMD0_FAIL;
                    end else begin
                      launch       = 1'b1;
                      launch_frame = sdspi_pkg::cmd_frame(sdspi_pkg::CMD_IF_COND,
                                                          sdspi_pkg::ARG_CMD8,
                                                          sdspi_pkg::CRC_CMD8);
                    end
                  end
                  sdspi_pkg::CMD_IF_COND: begin
                    if (rx == sdspi_pkg::R1_IDLE) begin
                      phase_d = PH_TRAIL8;
                      byte_d  = '0;
                    end else begin
                      retry_d      = '0;
                      launch       = 1'b1;
                      launch_frame = sdspi_pkg::cmd_frame(sdspi_pkg::CMD_APP, 32'd0,
                                                          sdspi_pkg::CRC_NONE);
                    end
                  end
                  sdspi_pkg::CMD_APP: begin
                    launch       = 1'b1;
                    launch_frame = sdspi_pkg::cmd_frame(sdspi_pkg::CMD_SEND_OP,
                                                        sdspi_pkg::ARG_ACMD41,
                                                        sdspi_pkg::CRC_NONE);
                  end
                  sdspi_pkg::CMD_SEND_OP: begin
                    retry_d = retry_inc;
                    if (rx == sdspi_pkg::R1_READY) begin
                      launch       = 1'b1;
                      launch_frame = sdspi_pkg::cmd_frame(sdspi_pkg::CMD_READ_OCR, 32'd0,
                                                          sdspi_pkg::CRC_NONE);
                    end else if (retry_inc >= retry_lim_eff) begin
                      fin_en = 1'b1;
                      fin_st = sdspi_pkg::ST_ACMD41_FAIL;
                    end else begin
                      launch       = 1'b1;
                      launch_frame = sdspi_pkg::cmd_frame(sdspi_pkg::CMD_APP, 32'd0,
                                                          sdspi_pkg::CRC_NONE);
                    end
                  end
                  sdspi_pkg::CMD_READ_OCR: begin
                    if (rx == sdspi_pkg::R1_READY) begin
                      phase_d = PH_OCR;
                      byte_d  = '0;
                    end else begin
                      div_d  = cfg_i.fast_div;
                      fin_en = 1'b1;
                    end
                  end
                  sdspi_pkg::CMD_BLOCKLEN: begin
                    div_d  = cfg_i.fast_div;
                    fin_en = 1'b1;
                  end
                  default: begin
                    // single block read
                    if (rx != sdspi_pkg::R1_READY) begin
                      fin_en = 1'b1;
                      fin_st = sdspi_pkg::ST_READ_REJ;
                    end else begin
                      phase_d = PH_TOKEN;
                      poll_d  = '0;
                    end
                  end
                endcase
              end
            end
            // trailing bytes of the interface condition reply
            PH_TRAIL8: begin
              byte_d = byte_inc;
              if (byte_inc >= BW'(sdspi_pkg::TRAIL_BYTES)) begin
                if (rx != sdspi_pkg::CHECK_BYTE) begin
                  fin_en = 1'b1;
                  fin_st = sdspi_pkg::ST_CMD8_FAIL;
                end else begin
                  retry_d      = '0;
                  launch       = 1'b1;
                  launch_frame = sdspi_pkg::cmd_frame(sdspi_pkg::CMD_APP, 32'd0,
                                                      sdspi_pkg::CRC_NONE);
                end
              end
            end
            // ocr bytes, first one holds the capacity bit
            PH_OCR: begin
              lr_d   = lr_eff;
              byte_d = byte_inc;
              if (byte_inc >= BW'(sdspi_pkg::TRAIL_BYTES)) begin
                if (lr_eff[sdspi_pkg::OCR_CCS_BIT]) begin
                  hc_d   = 1'b1;
                  div_d  = cfg_i.fast_div;
                  fin_en = 1'b1;
                end else begin
                  launch       = 1'b1;
                  launch_frame = sdspi_pkg::cmd_frame(sdspi_pkg::CMD_BLOCKLEN,
                                                      sdspi_pkg::ARG_BLOCKLEN,
                                                      sdspi_pkg::CRC_NONE);
                end
              end
            end
            // wait for the start token
            PH_TOKEN: begin
              poll_d = poll_inc;
              if (rx == sdspi_pkg::START_TOKEN) begin
                phase_d = PH_DATA;
                byte_d  = '0;
              end else if (poll_inc >= token_lim_eff) begin
                fin_en = 1'b1;
                fin_st = sdspi_pkg::ST_NO_TOKEN;
              end
            end
            // block data beats
            PH_DATA: begin
              res_d.data_byte  = rx;
              res_d.data_valid = 1'b1;
              byte_d           = byte_inc;
              if (byte_inc >= BW'(sdspi_pkg::BLOCK_BYTES)) begin
                res_d.data_last = 1'b1;
                phase_d         = PH_CRC;
                byte_d          = '0;
              end
            end
            PH_CRC: begin
              byte_d = byte_inc;
              if (byte_inc >= BW'(sdspi_pkg::CRC_BYTES)) fin_en = 1'b1;
            end
            default: res_d.tx_valid = 1'b0;
          endcase
        end
        default: ;
      endcase
    end

    // start a command frame
    if (launch) begin
      frame_d        = launch_frame;
      phase_d        = PH_CMD;
      byte_d         = BW'(1);
      res_d.tx_byte  = launch_frame[47:40];
      res_d.tx_valid = 1'b1;
    end
    // end of the operation
    if (fin_en) begin
      phase_d        = PH_IDLE;
      res_d.done_res = 1'b1;
      res_d.status   = fin_st;
      res_d.tx_valid = 1'b0;
      res_d.tx_byte  = sdspi_pkg::IDLE_BYTE;
    end

    res_d.chip_select   = sel_d;
    res_d.clock_divider = div_d;
    res_d.high_capacity = hc_d;

    res_valid_d = fire_i ? has_res : (res_valid_q && !out_ready_i);
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      byte_q      <= '0;
      poll_q      <= '0;
      retry_q     <= '0;
      frame_q     <= '0;
      hc_q        <= 1'b0;
      lr_q        <= '0;
      div_q       <= sdspi_pkg::SLOW_DIV_RST;
      sel_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      byte_q      <= byte_d;
      poll_q      <= poll_d;
      retry_q     <= retry_d;
      frame_q     <= frame_d;
      hc_q        <= hc_d;
      lr_q        <= lr_d;
      div_q       <= div_d;
      sel_q       <= sel_d;
      res_valid_q <= res_valid_d;
      if (fire_i) res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: hw/rtl/sd_spi_init_and_block_read_top.sv
// top level of the sd card spi-mode master: request register, sequencer, registers
// depends on sdspi_pkg, sdspi_req_if, sdspi_res_if, sdspi_cfg and sdspi_fsm
//
// Usage: the req channel carries init requests, block read requests and
// every byte clocked in from the card. Each accepted beat gives at most one
// res beat naming the next byte to clock out (tx_valid), the chip select
// level and the spi clock divider, plus block data, completion and status.
// A byte beat while idle and request code 3 give no result.
// An accepted request passes through the request register and then the
// sequencer, which writes the result register. Throughput: one beat per
// cycle while the receiver takes each result, set by the state update of
// the sequencer; a stalled result holds the flow.
// The request register and the result register decouple the two sides, so a
// new request is taken while a finished result still waits. When the
// receiver stalls, the result holds and one further request is buffered;
// ready then drops until the result is taken.
// Reset: the sequencer goes idle, chip select off, slow divider (101) in
// use, registers at their default values. The user must make configuration writes
// through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle; the block does not enforce it.
module sd_spi_init_and_block_read_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sdspi_req_if.sink                        req_i,
  sdspi_res_if.source                      res_o,
  input  logic                             cfg_we_i,
  input  logic [sdspi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdspi_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  sdspi_pkg::cfg_t cfg;
  sdspi_pkg::req_t in_q;
  sdspi_pkg::res_t res;
  logic            in_valid_q;
  logic            res_valid;
  logic            out_free;
  logic            fire;
  logic            take;

  // handshake of the request register
  assign out_free    = !res_valid || res_o.ready;
  assign fire        = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || fire;
  assign take        = req_i.valid && req_i.ready;

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= take || (in_valid_q && !fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q.req_type  <= req_i.req_type;
      in_q.block_num <= req_i.block_num;
      in_q.rx_byte   <= req_i.rx_byte;
    end
  end

  sdspi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sdspi_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (fire),
    .item_i      (in_q),
    .out_ready_i (res_o.ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result channel
  assign res_o.valid         = res_valid;
  assign res_o.tx_byte       = res.tx_byte;
  assign res_o.tx_valid      = res.tx_valid;
  assign res_o.chip_select   = res.chip_select;
  assign res_o.clock_divider = res.clock_divider;
  assign res_o.data_byte     = res.data_byte;
  assign res_o.data_valid    = res.data_valid;
  assign res_o.data_last     = res.data_last;
  assign res_o.done_res      = res.done_res;
  assign res_o.status        = res.status;
  assign res_o.high_capacity = res.high_capacity;

  // a buffered request is neither lost nor altered while it waits
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_q))
    else $error("buffered request changed while stalled");

  // a finished operation asks for no further exchange
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.done_res |-> !res_o.tx_valid && res_o.tx_byte == sdspi_pkg::IDLE_BYTE)
    else $error("exchange requested on completion");

  // error codes only come with completion, data never comes with completion
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status != sdspi_pkg::ST_OK || res_o.data_valid)
      |-> res_o.done_res != res_o.data_valid)
    else $error("status or data beat inconsistent");

endmodule

// File: test/sdspi_tb_pkg.sv
`timescale 1ns / 1ps
// scoreboard for the sd card spi-mode master: exchange predictor and result check
// depends on sdspi_pkg
package sdspi_tb_pkg;
  import sdspi_pkg::*;

  // request code that the block ignores, and an r1 for an illegal command
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [7:0] R1_ILLEGAL = 8'h05;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_WAKE, SEQ_CMD, SEQ_RESP, SEQ_TRAIL8, SEQ_OCR, SEQ_TOKEN, SEQ_DATA, SEQ_CRC
  } seq_phase_e;

  class sdspi_exchange_sb;
    // register copies
    logic [7:0]  slow_div, fast_div, resp_lim;
    logic [11:0] retry_lim;
    logic [15:0] token_lim;

    // sequencer state as the card sees it
    seq_phase_e  ph;
    int unsigned byte_cnt, poll_cnt, retry_cnt;
    logic [47:0] frame;
    logic        block_mode, cs_now;
    logic [7:0]  last_r1, div_now;

    res_t        next_beat;
    res_t        expected_beats[$];
    int unsigned n_errors, n_checked;

    function new();
      slow_div   = SLOW_DIV_RST;
      fast_div   = FAST_DIV_RST;
      retry_lim  = RETRY_LIM_RST;
      token_lim  = TOKEN_LIM_RST;
      resp_lim   = RESP_LIM_RST;
      ph         = SEQ_IDLE;
      byte_cnt   = 0;
      poll_cnt   = 0;
      retry_cnt  = 0;
      frame      = '0;
      block_mode = 1'b0;
      cs_now     = 1'b0;
      last_r1    = '0;
      div_now    = SLOW_DIV_RST;
      n_errors   = 0;
      n_checked  = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] val);
      case (idx)
        CFG_SLOW_DIV:  slow_div  = val[7:0];
        CFG_FAST_DIV:  fast_div  = val[7:0];
        CFG_RETRY_LIM: retry_lim = val[11:0];
        CFG_TOKEN_LIM: token_lim = val;
        CFG_RESP_LIM:  resp_lim  = val[7:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_beats.size();
    endfunction

    // a limit of zero behaves as one
    function int unsigned lim_or_one(int unsigned v);
      return (v == 0) ? 1 : v;
    endfunction

    function void emit(logic [7:0] b);
      next_beat.tx_byte  = b;
      next_beat.tx_valid = 1'b1;
    endfunction

    function void finish_op(status_e st);
      ph                 = SEQ_IDLE;
      next_beat.done_res = 1'b1;
      next_beat.status   = st;
      next_beat.tx_valid = 1'b0;
      next_beat.tx_byte  = IDLE_BYTE;
    endfunction

    function void start_cmd(logic [5:0] idx, logic [31:0] arg, logic [7:0] crc);
      frame    = {2'b01, idx, arg, crc};
      ph       = SEQ_CMD;
      byte_cnt = 1;
      emit(frame[47:40]);
    endfunction

    function void init_ok();
      div_now = fast_div;
      finish_op(ST_OK);
    endfunction

    // r1 response to the command in the frame
    function void take_r1(logic [7:0] r);
      last_r1 = r;
      case (frame[45:40])
        CMD_GO_IDLE: begin
          if (r != R1_IDLE) finish_op(ST_CMD0_FAIL);
          else start_cmd(CMD_IF_COND, ARG_CMD8, CRC_CMD8);
        end
        CMD_IF_COND: begin
          if (r == R1_IDLE) begin
            ph       = SEQ_TRAIL8;
            byte_cnt = 0;
            emit(IDLE_BYTE);
          end else begin
            retry_cnt = 0;
            start_cmd(CMD_APP, '0, CRC_NONE);
          end
        end
        CMD_APP: start_cmd(CMD_SEND_OP, ARG_ACMD41, CRC_NONE);
        CMD_SEND_OP: begin
          retry_cnt++;
          if (r == R1_READY) start_cmd(CMD_READ_OCR, '0, CRC_NONE);
          else if (retry_cnt >= lim_or_one(retry_lim)) finish_op(ST_ACMD41_FAIL);
          else start_cmd(CMD_APP, '0, CRC_NONE);
        end
        CMD_READ_OCR: begin
          if (r == R1_READY) begin
            ph       = SEQ_OCR;
            byte_cnt = 0;
            emit(IDLE_BYTE);
          end else begin
            init_ok();
          end
        end
        CMD_BLOCKLEN: init_ok();
        default: begin
          if (r != R1_READY) begin
            finish_op(ST_READ_REJ);
          end else begin
            ph       = SEQ_TOKEN;
            poll_cnt = 0;
            emit(IDLE_BYTE);
          end
        end
      endcase
    endfunction

    // one byte clocked in from the card
    function void take_byte(logic [7:0] rx);
      case (ph)
        SEQ_WAKE: begin
          byte_cnt++;
          if (byte_cnt < WAKE_BYTES) begin
            emit(IDLE_BYTE);
          end else begin
            cs_now = 1'b1;
            start_cmd(CMD_GO_IDLE, '0, CRC_CMD0);
          end
        end
        SEQ_CMD: begin
          if (byte_cnt < FRAME_BYTES) begin
            emit(frame[8*(FRAME_BYTES-1-byte_cnt) +: 8]);
            byte_cnt++;
          end else begin
            ph       = SEQ_RESP;
            poll_cnt = 0;
            emit(IDLE_BYTE);
          end
        end
        SEQ_RESP: begin
          poll_cnt++;
          if (!rx[R1_BUSY_BIT] || poll_cnt >= lim_or_one(resp_lim)) take_r1(rx);
          else emit(IDLE_BYTE);
        end
        SEQ_TRAIL8: begin
          byte_cnt++;
          if (byte_cnt < TRAIL_BYTES) begin
            emit(IDLE_BYTE);
          end else if (rx != CHECK_BYTE) begin
            finish_op(ST_CMD8_FAIL);
          end else begin
            retry_cnt = 0;
            start_cmd(CMD_APP, '0, CRC_NONE);
          end
        end
        SEQ_OCR: begin
          if (byte_cnt == 0) last_r1 = rx;
          byte_cnt++;
          if (byte_cnt < TRAIL_BYTES) begin
            emit(IDLE_BYTE);
          end else if (last_r1[OCR_CCS_BIT]) begin
            block_mode = 1'b1;
            init_ok();
          end else begin
            start_cmd(CMD_BLOCKLEN, ARG_BLOCKLEN, CRC_NONE);
          end
        end
        SEQ_TOKEN: begin
          poll_cnt++;
          if (rx == START_TOKEN) begin
            ph       = SEQ_DATA;
            byte_cnt = 0;
            emit(IDLE_BYTE);
          end else if (poll_cnt >= lim_or_one(token_lim)) begin
            finish_op(ST_NO_TOKEN);
          end else begin
            emit(IDLE_BYTE);
          end
        end
        SEQ_DATA: begin
          next_beat.data_byte  = rx;
          next_beat.data_valid = 1'b1;
          byte_cnt++;
          emit(IDLE_BYTE);
          if (byte_cnt >= BLOCK_BYTES) begin
            next_beat.data_last = 1'b1;
            ph       = SEQ_CRC;
            byte_cnt = 0;
          end
        end
        default: begin
          byte_cnt++;
          if (byte_cnt < CRC_BYTES) emit(IDLE_BYTE);
          else finish_op(ST_OK);
        end
      endcase
    endfunction

    // accepted request beat: returns 1 when a result beat is due
    function bit note_request(req_t rq);
      next_beat         = '0;
      next_beat.tx_byte = IDLE_BYTE;
      case (rq.req_type)
        REQ_INIT: begin
          block_mode = 1'b0;
          div_now    = slow_div;
          cs_now     = 1'b0;
          ph         = SEQ_WAKE;
          byte_cnt   = 0;
          emit(IDLE_BYTE);
        end
        REQ_READ: begin
          start_cmd(CMD_READ_ONE, block_mode ? rq.block_num : rq.block_num << ADDR_SHIFT,
                    CRC_NONE);
        end
        REQ_BYTE: begin
          if (ph == SEQ_IDLE) return 1'b0;
          take_byte(rq.rx_byte);
        end
        default: return 1'b0;
      endcase
      next_beat.chip_select   = cs_now;
      next_beat.clock_divider = div_now;
      next_beat.high_capacity = block_mode;
      expected_beats.push_back(next_beat);
      return 1'b1;
    endfunction

    function void match_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        n_errors++;
        if (n_errors <= 100) $error("%s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_beats.size() == 0) begin
        n_errors++;
        if (n_errors <= 100) $error("result beat with nothing expected, tx_byte %0h", got.tx_byte);
        return;
      end
      want = expected_beats.pop_front();
      n_checked++;
      match_field("tx_byte", want.tx_byte, got.tx_byte);
      match_field("tx_valid", want.tx_valid, got.tx_valid);
      match_field("chip_select", want.chip_select, got.chip_select);
      match_field("clock_divider", want.clock_divider, got.clock_divider);
      match_field("data_byte", want.data_byte, got.data_byte);
      match_field("data_valid", want.data_valid, got.data_valid);
      match_field("data_last", want.data_last, got.data_last);
      match_field("done_res", want.done_res, got.done_res);
      match_field("status", want.status, got.status);
      match_field("high_capacity", want.high_capacity, got.high_capacity);
    endfunction
  endclass

endpackage

// File: test/sd_spi_init_and_block_read_top_tb.sv
`timescale 1ns / 1ps
// testbench top: emulates a card answering the sd spi-mode master, checks every result beat
// depends on sdspi_pkg, sdspi_req_if, sdspi_res_if, sdspi_tb_pkg and the top level
module sd_spi_init_and_block_read_top_tb;
  import sdspi_pkg::*;
  import sdspi_tb_pkg::*;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_PERIODIC} stall_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sdspi_req_if req_ch();
  sdspi_res_if res_ch();

  sdspi_exchange_sb sb;

  int burst_left = 0;
  int abort_in = -1;

  sd_spi_init_and_block_read_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run ends here if the block hangs
  initial begin : watchdog
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // card reply to the byte the block is clocking out, mostly well formed
  function automatic logic [7:0] card_reply();
    logic [7:0] any;
    int         r;
    any = 8'($urandom_range(255));
    r   = $urandom_range(99);
    case (sb.ph)
      SEQ_RESP: begin
        if (r < 30) return {1'b1, any[6:0]};
        r = $urandom_range(99);
        case (sb.frame[45:40])
          CMD_GO_IDLE:  return (r < 85) ? R1_IDLE : {1'b0, any[6:0]};
          CMD_IF_COND:  return (r < 60) ? R1_IDLE : (r < 90) ? R1_ILLEGAL : {1'b0, any[6:0]};
          CMD_SEND_OP:  return (r < 35) ? R1_READY : R1_IDLE;
          CMD_READ_OCR: return (r < 85) ? R1_READY : {1'b0, any[6:0]};
          CMD_READ_ONE: return (r < 85) ? R1_READY : {1'b0, any[6:0]};
          default:      return {1'b0, any[6:0]};
        endcase
      end
      SEQ_TRAIL8: return (sb.byte_cnt == TRAIL_BYTES - 1 && r < 85) ? CHECK_BYTE : any;
      SEQ_TOKEN:  return (r < 30) ? START_TOKEN : (r < 85) ? IDLE_BYTE : any;
      default:    return any;
    endcase
  endfunction

  // new init or block read, some of them cut short by a later request
  function automatic req_t fresh_op();
    req_t it;
    it.rx_byte  = 8'($urandom_range(255));
    it.req_type = ($urandom_range(99) < 40) ? REQ_INIT : REQ_READ;
    case ($urandom_range(3))
      0:       it.block_num = $urandom_range(15);
      1:       it.block_num = 32'hFFFF_FFFF - $urandom_range(15);
      default: it.block_num = $urandom();
    endcase
    abort_in = ($urandom_range(99) < 15) ? $urandom_range(30) : -1;
    return it;
  endfunction

  function automatic req_t pick_item();
    req_t it;
    int   r;
    it.req_type  = REQ_BYTE;
    it.block_num = $urandom();
    it.rx_byte   = 8'($urandom_range(255));
    r = $urandom_range(99);
    if (sb.ph == SEQ_IDLE) begin
      // stray bytes and the unused code now and then
      if (r >= 9) it = fresh_op();
      else if (r >= 6) it.req_type = REQ_UNUSED;
    end else if (abort_in == 0) begin
      it = fresh_op();
    end else begin
      if (abort_in > 0) abort_in--;
      if (r < 2) it.req_type = REQ_UNUSED;
      else it.rx_byte = card_reply();
    end
    return it;
  endfunction

  // one request beat, with bursts and gaps on the sending side
  task automatic send_item(input req_t it, output bit counted);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= it.req_type;
    req_ch.block_num <= it.block_num;
    req_ch.rx_byte   <= it.rx_byte;
    do @(posedge clk_i); while (!req_ch.ready);
    counted = sb.note_request(it);
  endtask

  // stop sending until every expected beat is back
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_regs(input logic [15:0] vals [5]);
    for (int i = 0; i < 5; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      sb.set_reg(cfg_idx_e'(i), vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // random traffic until the quota is met, a running operation carries on later
  task automatic run_phase(int quota);
    int   done_items;
    bit   paused;
    bit   counted;
    req_t it;
    done_items = 0;
    paused     = 1'b0;
    forever begin
      if (!paused && done_items >= quota / 2) begin
        paused = 1'b1;
        drain();
      end
      if (done_items >= quota) break;
      it = pick_item();
      send_item(it, counted);
      done_items += counted;
    end
  endtask

  initial begin : stimulus
    req_t        directed[$];
    logic [15:0] regs [5];
    bit          counted;
    sb = new();
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_BYTE;
    req_ch.block_num <= '0;
    req_ch.rx_byte   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle bytes, unused code, read before init, aborts, polling
    directed.push_back('{REQ_BYTE, 32'h0000_0000, 8'h00});
    directed.push_back('{REQ_BYTE, 32'hFFFF_FFFF, 8'hFF});
    directed.push_back('{REQ_UNUSED, 32'hFFFF_FFFF, 8'hFF});
    directed.push_back('{REQ_READ, 32'hFFFF_FFFF, 8'h00});
    directed.push_back('{REQ_READ, 32'h0000_0000, 8'hFF});
    for (int i = 0; i < 6; i++) directed.push_back('{REQ_BYTE, $urandom(), 8'($urandom_range(255))});
    directed.push_back('{REQ_BYTE, 32'h0000_0000, 8'hFF});
    directed.push_back('{REQ_BYTE, 32'h0000_0000, 8'h85});
    directed.push_back('{REQ_BYTE, 32'hFFFF_FFFF, R1_ILLEGAL});
    directed.push_back('{REQ_INIT, 32'hFFFF_FFFF, 8'hFF});
    directed.push_back('{REQ_UNUSED, 32'h0000_0000, 8'h00});
    directed.push_back('{REQ_INIT, 32'h0000_0000, 8'h00});
    directed.push_back('{REQ_BYTE, 32'h0000_0000, 8'h00});
    directed.push_back('{REQ_BYTE, 32'hFFFF_FFFF, 8'hFF});
    directed.push_back('{REQ_BYTE, 32'h0000_0000, CHECK_BYTE});
    foreach (directed[i]) send_item(directed[i], counted);

    // reset settings first, then zero limits, maxima and random ones
    run_phase(100);
    for (int p = 1; p < 5; p++) begin
      drain();
      repeat (4) @(posedge clk_i);
      case (p)
        1: regs = '{16'd0, 16'd255, 16'd0, 16'd0, 16'd0};
        2: regs = '{16'd255, 16'd0, 16'd4095, 16'd65535, 16'd255};
        3: regs = '{16'($urandom_range(255)), 16'($urandom_range(255)),
                    16'($urandom_range(1, 4)), 16'($urandom_range(1, 6)),
                    16'($urandom_range(1, 3))};
        default: regs = '{16'($urandom_range(255)), 16'($urandom_range(255)),
                          16'($urandom_range(1, 20)), 16'($urandom_range(1, 40)),
                          16'($urandom_range(1, 12))};
      endcase
      write_regs(regs);
      run_phase(100);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiving side: ready pattern changes every so often, one long hold-off
  initial begin : result_sink
    stall_mode_e mode;
    int          left;
    bit          held;
    int unsigned cyc;
    mode = STALL_NONE;
    left = 0;
    held = 1'b0;
    cyc  = 0;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (!held && sb.n_checked >= 85) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(3));
        left = $urandom_range(20, 120);
      end
      left--;
      case (mode)
        STALL_NONE:   res_ch.ready <= 1'b1;
        STALL_COIN:   res_ch.ready <= 1'($urandom_range(1));
        STALL_SPARSE: res_ch.ready <= ($urandom_range(3) == 0);
        default:      res_ch.ready <= (cyc % 5 != 0) && (cyc % 7 != 0);
      endcase
    end
  end

  // every accepted result beat against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      sb.check_result({res_ch.tx_byte, res_ch.tx_valid, res_ch.chip_select,
                       res_ch.clock_divider, res_ch.data_byte, res_ch.data_valid,
                       res_ch.data_last, res_ch.done_res, res_ch.status,
                       res_ch.high_capacity});
    end
  end

endmodule
